### sv/double_to_custom_float_defines.svh
// Assertion macros for the double to custom float converter
`ifndef DOUBLE_TO_CUSTOM_FLOAT_DEFINES_SVH
`define DOUBLE_TO_CUSTOM_FLOAT_DEFINES_SVH
`ifndef SYNTHESIS
`define DTCF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DTCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DTCF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DTCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/dtcf_pkg.sv
`default_nettype none

package dtcf_pkg;

    localparam int DBL_BIAS = 1023;
    localparam int DBL_FRAC = 52;
    localparam int DBL_SIGN = 63;
    localparam int DBL_EXPW = 11;

    localparam int XW     = 14;
    localparam int EXPF_W = 62;
    localparam int FRAC_W = 61;

    typedef logic [5:0]            t_lzc_cnt;
    typedef logic signed [XW-1:0]  t_xs;

    typedef logic [1:0] t_cls;
    localparam t_cls CLS_ZERO = 2'd0;
    localparam t_cls CLS_SPEC = 2'd1;
    localparam t_cls CLS_FIN  = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TOTAL_BITS = 2'd0;
    localparam t_cfg_idx CFG_EXP_BITS   = 2'd1;

endpackage

`default_nettype wire

### sv/dtcf_lzc.sv
`default_nettype none

module dtcf_lzc (
    input  logic [dtcf_pkg::DBL_FRAC-1:0] i_vec,
    output dtcf_pkg::t_lzc_cnt            o_cnt
);
    import dtcf_pkg::*;

    // highest set bit wins
    always_comb begin
        o_cnt = '0;
        for (int i = 0; i < DBL_FRAC; i++) begin
            if (i_vec[i]) begin
                o_cnt = t_lzc_cnt'(DBL_FRAC - 1 - i);
            end
        end
    end

endmodule

`default_nettype wire

### sv/double_to_custom_float.sv
// Channel  Handshake                 Beat
// input    i_valid / o_stall         i_double_bits
// output   o_valid / i_stall         o_custom_bits, o_format_error
// config   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Four register stages: decode and leading-zero count, normalise and rebias,
// fraction shift and special cases, packing into the output register.
// One beat enters per cycle while o_stall is low.
// Synchronous reset clears the stage valid bits and sets the format to 32/8.
// A stage holds while its successor is full and stalled; o_stall rises only
// when all four stages are full and i_stall is high. o_cfg_ready is always high.
`default_nettype none
`include "double_to_custom_float_defines.svh"

module double_to_custom_float (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [63:0]           i_double_bits,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [63:0]           o_custom_bits,
    output logic                  o_format_error,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  dtcf_pkg::t_cfg_idx    i_cfg_index,
    input  logic [6:0]            i_cfg_data
);
    import dtcf_pkg::*;

    logic [6:0]  r_total_bits;
    logic [5:0]  r_exp_bits;

    logic [7:0]  w_diff;
    logic        w_fmt_err;
    logic [5:0]  w_fb;
    logic [63:0] w_bias64;
    logic [63:0] w_allones64;
    logic [63:0] w_frac_mask;
    logic        w_exp_small;
    t_xs         w_bias_s;

    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic en_a, en_b, en_c, en_d;

    // stage A
    logic [DBL_EXPW-1:0] w_e11;
    logic [DBL_FRAC-1:0] w_f52;
    logic                w_sub;
    t_lzc_cnt            w_lz;
    t_cls                w_cls;
    t_xs                 w_x;

    logic                r_sign_a;
    t_cls                r_cls_a;
    logic                r_nan_a;
    logic [DBL_FRAC:0]   r_mant_a;
    t_lzc_cnt            r_lz_a;
    t_xs                 r_x_a;

    // stage B
    logic [DBL_FRAC:0]   w_mn;
    logic                w_ovf, w_unf;
    t_xs                 w_t;
    logic [63:0]         w_expf_sum;

    logic                r_sign_b;
    t_cls                r_cls_b;
    logic                r_nan_b;
    logic                r_ovf_b;
    logic                r_unf_b;
    logic [DBL_FRAC:0]   r_mn_b;
    logic [EXPF_W-1:0]   r_expf_b;
    t_xs                 r_t_b;

    // stage C
    logic [DBL_FRAC:0]   w_val;
    t_xs                 w_sh;
    t_xs                 w_nsh;
    logic [63:0]         w_shifted;
    logic [63:0]         w_frac_full;
    logic [EXPF_W-1:0]   w_expf_c;
    logic [FRAC_W-1:0]   w_frac_c;

    logic                r_sign_c;
    logic [EXPF_W-1:0]   r_expf_c;
    logic [FRAC_W-1:0]   r_frac_c;

    // stage D
    logic [63:0]         w_word;
    logic [63:0]         r_custom_bits;
    logic                r_format_error;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_bits <= 7'd32;
            r_exp_bits   <= 6'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TOTAL_BITS: r_total_bits <= i_cfg_data;
                CFG_EXP_BITS:   r_exp_bits   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_diff      = {1'b0, r_total_bits} - {2'b00, r_exp_bits};
        w_fmt_err   = ($signed(w_diff) < 8'sd2) || (r_total_bits > 7'd64)
                      || (r_exp_bits < 6'd2);
        w_fb        = 6'(w_diff - 8'd1);
        w_bias64    = (64'd1 << (r_exp_bits - 6'd1)) - 64'd1;
        w_allones64 = (64'd1 << r_exp_bits) - 64'd1;
        w_frac_mask = (64'd1 << w_fb) - 64'd1;
        w_exp_small = r_exp_bits <= 6'(DBL_EXPW);
        w_bias_s    = t_xs'({1'b0, w_bias64[DBL_EXPW-1:0]});
    end

    assign en_d    = !r_vld_d || !i_stall;
    assign en_c    = !r_vld_c || en_d;
    assign en_b    = !r_vld_b || en_c;
    assign en_a    = !r_vld_a || en_b;
    assign o_stall = !en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (en_a) begin
                r_vld_a <= i_valid;
            end
            if (en_b) begin
                r_vld_b <= r_vld_a;
            end
            if (en_c) begin
                r_vld_c <= r_vld_b;
            end
            if (en_d) begin
                r_vld_d <= r_vld_c;
            end
        end
    end

    // stage A: decode
    assign w_e11 = i_double_bits[DBL_FRAC +: DBL_EXPW];
    assign w_f52 = i_double_bits[DBL_FRAC-1:0];
    assign w_sub = (w_e11 == '0);

    dtcf_lzc u_lzc (
        .i_vec (w_f52),
        .o_cnt (w_lz)
    );

    always_comb begin
        if (w_sub && (w_f52 == '0)) begin
            w_cls = CLS_ZERO;
        end else if (w_e11 == '1) begin
            w_cls = CLS_SPEC;
        end else begin
            w_cls = CLS_FIN;
        end
        if (w_sub) begin
            w_x = t_xs'(-DBL_BIAS) - t_xs'(w_lz);
        end else begin
            w_x = t_xs'({1'b0, w_e11}) - t_xs'(DBL_BIAS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_sign_a <= i_double_bits[DBL_SIGN];
            r_cls_a  <= w_cls;
            r_nan_a  <= (w_f52 != '0);
            r_mant_a <= {!w_sub, w_f52};
            r_lz_a   <= w_sub ? t_lzc_cnt'(w_lz + t_lzc_cnt'(1)) : '0;
            r_x_a    <= w_x;
        end
    end

    // stage B: normalise, range checks, rebias
    always_comb begin
        w_mn       = r_mant_a << r_lz_a;
        w_ovf      = w_exp_small && (r_x_a > w_bias_s);
        w_unf      = w_exp_small && (r_x_a < (t_xs'(1) - w_bias_s));
        w_t        = r_x_a - t_xs'(1) + w_bias_s + t_xs'(w_fb) - t_xs'(DBL_FRAC);
        w_expf_sum = 64'(r_x_a) + w_bias64;
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_sign_b <= r_sign_a;
            r_cls_b  <= r_cls_a;
            r_nan_b  <= r_nan_a;
            r_ovf_b  <= w_ovf;
            r_unf_b  <= w_unf;
            r_mn_b   <= w_mn;
            r_expf_b <= w_expf_sum[EXPF_W-1:0];
            r_t_b    <= w_t;
        end
    end

    // stage C: fraction alignment and special values
    always_comb begin
        w_val = r_unf_b ? r_mn_b : {1'b0, r_mn_b[DBL_FRAC-1:0]};
        w_sh  = r_unf_b ? r_t_b : (t_xs'(w_fb) - t_xs'(DBL_FRAC));
        w_nsh = -w_sh;
        if (w_sh >= 0) begin
            w_shifted = 64'(w_val) << w_sh[3:0];
        end else if (|w_nsh[XW-1:6]) begin
            w_shifted = '0;
        end else begin
            w_shifted = 64'(w_val) >> w_nsh[5:0];
        end
        w_frac_full = w_shifted & w_frac_mask;

        case (r_cls_b)
            CLS_ZERO: begin
                w_expf_c = '0;
                w_frac_c = '0;
            end
            CLS_SPEC: begin
                w_expf_c = w_allones64[EXPF_W-1:0];
                w_frac_c = FRAC_W'(r_nan_b);
            end
            CLS_FIN: begin
                if (r_ovf_b) begin
                    w_expf_c = w_allones64[EXPF_W-1:0];
                    w_frac_c = '0;
                end else if (r_unf_b) begin
                    w_expf_c = '0;
                    w_frac_c = w_frac_full[FRAC_W-1:0];
                end else begin
                    w_expf_c = r_expf_b;
                    w_frac_c = w_frac_full[FRAC_W-1:0];
                end
            end
            default: begin
                w_expf_c = '0;
                w_frac_c = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_sign_c <= r_sign_b;
            r_expf_c <= w_expf_c;
            r_frac_c <= w_frac_c;
        end
    end

    // stage D: pack
    assign w_word = (64'(r_sign_c) << (r_total_bits - 7'd1))
                  | (64'(r_expf_c) << w_fb)
                  | 64'(r_frac_c);

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_custom_bits  <= w_fmt_err ? 64'd0 : w_word;
            r_format_error <= w_fmt_err;
        end
    end

    assign o_valid        = r_vld_d;
    assign o_custom_bits  = r_custom_bits;
    assign o_format_error = r_format_error;

    `DTCF_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && o_format_error, o_custom_bits == 64'd0, "format error beat carries non-zero bits")
    `DTCF_ASSERT_IMPL(a_upper_zero, i_clk, i_rst_n, o_valid && !o_format_error, (o_custom_bits >> r_total_bits) == 64'd0, "bits set above the format width")
    `DTCF_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, o_stall, r_vld_a && r_vld_b && r_vld_c && r_vld_d, "stall raised with a free stage")
    `DTCF_ASSERT_NEXT(a_hold_b, i_clk, i_rst_n, r_vld_b && !en_b, r_vld_b && $stable(r_mn_b), "held stage lost its beat")

endmodule

`default_nettype wire

### tb/tb_double_to_custom_float.sv
`timescale 1ns / 1ps

module tb_double_to_custom_float;
    import dtcf_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam t_cfg_idx CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [63:0] bits;
        logic        err;
    } t_conv;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [63:0] val;
        logic        typed;
        logic [63:0] exp_bits;
        logic        exp_err;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_double_bits;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_custom_bits;
    logic        o_format_error;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_idx    i_cfg_index;
    logic [6:0]  i_cfg_data;

    logic [6:0]  cur_total;
    logic [5:0]  cur_exp;
    t_conv       pending_custom [$];
    t_conv       want;
    t_conv       known_res;
    t_row        dir_rows [$];
    int          fail_cnt;
    int          quiet_cycles;
    int          stall_left;
    bit          hold_req;
    bit          tx_calm;
    bit          rx_calm;
    int          items_done;
    int          phase_no;
    int          n_items;

    double_to_custom_float dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_double_bits  (i_double_bits),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_custom_bits  (o_custom_bits),
        .o_format_error (o_format_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_conv convert_double(logic [63:0] d, logic [6:0] tot, logic [5:0] ew);
        t_conv       res;
        longint      tw, xw, fw, bias, q, x, s, e11v;
        logic [63:0] m, r, expf, frac, allones;
        int          p;
        res.bits = '0;
        res.err = 1'b0;
        tw = tot;
        xw = ew;
        if (tw - xw < 2 || tw > 64 || xw < 2) begin
            res.err = 1'b1;
            return res;
        end
        fw = tw - xw - 1;
        bias = longint'((64'd1 << (xw - 1)) - 64'd1);
        allones = (64'd1 << xw) - 64'd1;
        e11v = d[62:52];
        if (e11v == 0 && d[51:0] == '0) begin
            expf = '0;
            frac = '0;
        end else if (e11v == 2047) begin
            expf = allones;
            frac = (d[51:0] != '0) ? 64'd1 : 64'd0;
        end else begin
            if (e11v == 0) begin
                m = {12'd0, d[51:0]};
                q = 1 - DBL_BIAS - DBL_FRAC;
            end else begin
                m = {11'd0, 1'b1, d[51:0]};
                q = e11v - DBL_BIAS - DBL_FRAC;
            end
            p = 0;
            for (int i = 0; i < 64; i++)
                if (m[i]) p = i;
            x = q + p;
            if (x > bias) begin
                expf = allones;
                frac = '0;
            end else if (x >= 1 - bias) begin
                r = m & ((64'd1 << p) - 64'd1);
                expf = x + bias;
                if (fw >= p) frac = r << (fw - p);
                else frac = r >> (p - fw);
            end else begin
                s = q - 1 + bias + fw;
                expf = '0;
                if (s >= 0) frac = (s < 64) ? (m << s) : 64'd0;
                else frac = (-s < 64) ? (m >> (-s)) : 64'd0;
                frac &= (64'd1 << fw) - 64'd1;
            end
        end
        res.bits = ({63'd0, d[63]} << (tw - 1)) | (expf << fw) | frac;
        return res;
    endfunction

    function automatic logic [63:0] pick_double(logic [6:0] tot, logic [5:0] ew);
        longint      tw, xw, fw, bias, t, e;
        logic [63:0] raw;
        logic [51:0] fr;
        logic        sg;
        int          r;
        sg = 1'($urandom_range(0, 1));
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: fr = '0;
            1: fr = '1;
            2: fr = 52'd1 << $urandom_range(0, 51);
            default: fr = raw[51:0];
        endcase
        r = $urandom_range(0, 99);
        if (r < 12) return {$urandom, $urandom};
        if (r < 25) return {sg, ($urandom_range(0, 1) != 0) ? 11'h7FF : 11'h000, fr};
        tw = tot;
        xw = ew;
        if (xw < 2) xw = 2;
        fw = tw - xw - 1;
        if (fw < 1) fw = 1;
        bias = longint'((64'd1 << (xw - 1)) - 64'd1);
        case ($urandom_range(0, 7))
            0: t = bias + 1;
            1: t = bias;
            2: t = 1 - bias;
            3: t = -bias;
            4: t = 1 - bias - fw;
            5: t = -bias - fw - longint'($urandom_range(0, 3));
            6: t = longint'($urandom_range(0, 2046)) - 1023;
            default: t = -bias + longint'($urandom_range(0, 8)) - 3;
        endcase
        e = t + 1023;
        if (e < 1) e = 1;
        if (e > 2046) e = 2046;
        return {sg, e[10:0], fr};
    endfunction

    task automatic pick_format(output logic [6:0] tot, output logic [5:0] ew);
        int t, x;
        case ($urandom_range(0, 13))
            0: begin t = 4;  x = 2;  end
            1: begin t = 64; x = 62; end
            2: begin t = 64; x = 2;  end
            3: begin t = 3;  x = 2;  end
            4: begin t = 63; x = 62; end
            5: begin t = 64; x = 11; end
            6: begin t = 16; x = 5;  end
            7: begin
                t = $urandom_range(3, 63);
                x = $urandom_range(t - 1, 62);
            end
            default: begin
                t = $urandom_range(4, 64);
                x = $urandom_range(2, (t - 2 > 62) ? 62 : t - 2);
            end
        endcase
        tot = 7'(t);
        ew = 6'(x);
    endtask

    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_row mk_beat(logic [63:0] d);
        t_row row;
        row = '0;
        row.kind = ROW_BEAT;
        row.val = d;
        return row;
    endfunction

    function automatic t_row mk_known(logic [63:0] d, logic [63:0] b, logic e);
        t_row row;
        row = mk_beat(d);
        row.typed = 1'b1;
        row.exp_bits = b;
        row.exp_err = e;
        return row;
    endfunction

    function automatic t_row mk_reg(t_cfg_idx idx, logic [6:0] v);
        t_row row;
        row = '0;
        row.kind = ROW_REG;
        row.idx = idx;
        row.val = {57'd0, v};
        return row;
    endfunction

    task automatic send_beat(logic [63:0] d, bit known, t_conv res);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_double_bits <= d;
        do @(posedge i_clk); while (o_stall);
        pending_custom.push_back(known ? res : convert_double(d, cur_total, cur_exp));
    endtask

    task automatic pause_tx(int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_custom.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [6:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TOTAL_BITS: cur_total = v;
            CFG_EXP_BITS:   cur_exp = v[5:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int n, bit hold);
        logic [6:0] tot;
        logic [5:0] ew;
        pick_format(tot, ew);
        wait_drained();
        write_reg(CFG_TOTAL_BITS, tot);
        write_reg(CFG_EXP_BITS, {1'($urandom_range(0, 1)), ew});
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_IDX, 7'($urandom_range(0, 127)));
        tx_calm = hold || ($urandom_range(0, 4) == 0);
        rx_calm = ($urandom_range(0, 4) == 0);
        if (hold) hold_req = 1'b1;
        for (int k = 0; k < n; k++) begin
            send_beat(pick_double(tot, ew), 1'b0, '0);
            pause_tx((k == n - 1) ? 1 : pick_gap());
        end
    endtask

    // receiver back-pressure, including one long hold-off
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            i_stall <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
        end else if (rx_calm) begin
            i_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    i_stall <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                4: begin
                    i_stall <= 1'b1;
                    stall_left <= $urandom_range(9, 39);
                end
                default: i_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_custom.size() == 0) begin
                $error("unexpected beat: custom_bits %h format_error %b",
                       o_custom_bits, o_format_error);
                fail_cnt++;
            end else begin
                want = pending_custom.pop_front();
                if (o_custom_bits !== want.bits) begin
                    $error("custom_bits: expected %h, actual %h", want.bits, o_custom_bits);
                    fail_cnt++;
                end
                if (o_format_error !== want.err) begin
                    $error("format_error: expected %b, actual %b", want.err, o_format_error);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_double_bits = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TOTAL_BITS;
        i_cfg_data = '0;
        fail_cnt = 0;
        quiet_cycles = 0;
        stall_left = 0;
        hold_req = 1'b0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        cur_total = 7'd32;
        cur_exp = 6'd8;

        dir_rows.push_back(mk_known(64'h0000000000000000, 64'h0000000000000000, 1'b0));
        dir_rows.push_back(mk_known(64'h8000000000000000, 64'h0000000080000000, 1'b0));
        dir_rows.push_back(mk_known(64'h7FF0000000000000, 64'h000000007F800000, 1'b0));
        dir_rows.push_back(mk_known(64'hFFF0000000000000, 64'h00000000FF800000, 1'b0));
        dir_rows.push_back(mk_known(64'h7FF8000000000001, 64'h000000007F800001, 1'b0));
        dir_rows.push_back(mk_known(64'hFFFFFFFFFFFFFFFF, 64'h00000000FF800001, 1'b0));
        dir_rows.push_back(mk_known(64'h3FF0000000000000, 64'h000000003F800000, 1'b0));
        dir_rows.push_back(mk_known(64'hC000000000000000, 64'h00000000C0000000, 1'b0));
        dir_rows.push_back(mk_known(64'h7FEFFFFFFFFFFFFF, 64'h000000007F800000, 1'b0));
        dir_rows.push_back(mk_beat(64'h0000000000000001));
        dir_rows.push_back(mk_beat(64'h000FFFFFFFFFFFFF));
        dir_rows.push_back(mk_beat(64'h0010000000000000));
        dir_rows.push_back(mk_beat(64'h37D8000000000000));
        dir_rows.push_back(mk_beat(64'h3FF8000000000000));
        dir_rows.push_back(mk_reg(CFG_TOTAL_BITS, 7'd64));
        dir_rows.push_back(mk_reg(CFG_EXP_BITS, 7'd11));
        dir_rows.push_back(mk_known(64'h3FF0000000000000, 64'h3FF0000000000000, 1'b0));
        dir_rows.push_back(mk_known(64'h0000000000000001, 64'h0000000000000001, 1'b0));
        dir_rows.push_back(mk_known(64'h8000000000000000, 64'h8000000000000000, 1'b0));
        dir_rows.push_back(mk_known(64'h7FEFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 1'b0));
        dir_rows.push_back(mk_beat(64'hAAAAAAAAAAAAAAAA));
        dir_rows.push_back(mk_reg(CFG_TOTAL_BITS, 7'd8));
        dir_rows.push_back(mk_known(64'h3FF0000000000000, 64'h0, 1'b1));
        dir_rows.push_back(mk_reg(CFG_TOTAL_BITS, 7'd3));
        dir_rows.push_back(mk_reg(CFG_EXP_BITS, 7'd2));
        dir_rows.push_back(mk_known(64'h7FF8000000000001, 64'h0, 1'b1));
        dir_rows.push_back(mk_reg(CFG_TOTAL_BITS, 7'd4));
        dir_rows.push_back(mk_known(64'h3FF0000000000000, 64'h0000000000000002, 1'b0));
        dir_rows.push_back(mk_reg(CFG_TOTAL_BITS, 7'd64));
        dir_rows.push_back(mk_reg(CFG_EXP_BITS, 7'd62));
        dir_rows.push_back(mk_known(64'h3FF0000000000000, 64'h3FFFFFFFFFFFFFFE, 1'b0));
        dir_rows.push_back(mk_known(64'hFFF0000000000000, 64'hFFFFFFFFFFFFFFFE, 1'b0));
        dir_rows.push_back(mk_beat(64'h5555555555555555));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                pause_tx(1);
                wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].val[6:0]);
            end else begin
                known_res.bits = dir_rows[i].exp_bits;
                known_res.err = dir_rows[i].exp_err;
                send_beat(dir_rows[i].val, dir_rows[i].typed, known_res);
            end
        end
        pause_tx(1);

        items_done = 0;
        phase_no = 0;
        while (items_done < ITEM_TARGET) begin
            n_items = $urandom_range(40, 120);
            if (n_items > ITEM_TARGET - items_done) n_items = ITEM_TARGET - items_done;
            run_phase(n_items, phase_no == 2);
            items_done += n_items;
            phase_no++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_custom.size() != 0) begin
            $error("custom_bits: %0d expected beats never arrived", pending_custom.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
